// File: rtl/core/flolc_pkg.sv
`timescale 1ns / 1ps

package flolc_pkg;

  // request opcodes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_BRIGHT = 2'd1;
  localparam logic [1:0] OP_FLASH  = 2'd2;
  localparam logic [1:0] OP_TORCH  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_SHORT    = 3'd0;
  localparam logic [2:0] CFG_LONG     = 3'd1;
  localparam logic [2:0] CFG_START    = 3'd2;
  localparam logic [2:0] CFG_END_LOW  = 3'd3;
  localparam logic [2:0] CFG_END_HIGH = 3'd4;
  localparam logic [2:0] CFG_AUTO_OFF = 3'd5;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  // command bytes
  localparam logic [7:0] CMD_OFF        = 8'hA0;
  localparam logic [7:0] CMD_TORCH_TAIL = 8'hA1;
  localparam logic [7:0] CMD_FLASH_TAIL = 8'hA2;
  localparam logic [7:0] CMD_FLASH_BASE = 8'h80;
  localparam logic [7:0] CMD_FLASH_MAX  = 8'h8C;
  localparam logic [7:0] CMD_TORCH_DEF  = 8'h65;

  // request value limits
  localparam logic [15:0] BRIGHT_TORCH_LO = 16'd125;
  localparam logic [15:0] BRIGHT_TORCH_HI = 16'd128;
  localparam logic [15:0] BRIGHT_FLASH_LO = 16'd129;
  localparam logic [15:0] BRIGHT_FLASH_HI = 16'd142;
  localparam logic [15:0] BRIGHT_FULL     = 16'd255;
  localparam logic [15:0] FLASH_MA_MAX    = 16'd1000;
  localparam logic [15:0] TORCH_MA_MAX    = 16'd224;

  // register reset values
  localparam logic [7:0]  RST_SHORT    = 8'd40;
  localparam logic [7:0]  RST_LONG     = 8'd80;
  localparam logic [7:0]  RST_START    = 8'd30;
  localparam logic [7:0]  RST_END_LOW  = 8'd20;
  localparam logic [11:0] RST_END_HIGH = 12'd1000;
  localparam logic [19:0] RST_AUTO_OFF = 20'd600000;

  typedef struct packed {
    logic [7:0]  short_time;
    logic [7:0]  long_time;
    logic [7:0]  start_time;
    logic [7:0]  end_low_time;
    logic [11:0] end_high_time;
    logic [19:0] auto_off_time;
  } cfg_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] first;
    logic [7:0] second;
    logic       two;
    logic       flash;
  } dec_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic rejected;
    logic timer_armed;
  } res_t;

  function automatic logic [7:0] torch_code(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h61;
      2'd1:    c = 8'h63;
      2'd2:    c = 8'h65;
      default: c = 8'h64;
    endcase
    return c;
  endfunction

  // a zero duration still lasts one tick
  function automatic logic [11:0] at_least_one(input logic [11:0] v);
    return (v == 12'd0) ? 12'd1 : v;
  endfunction

endpackage

// File: rtl/core/flash_led_one_wire_controller.sv
`timescale 1ns / 1ps
// latency: the result of an input transfer is on the out_ port the next cycle
// throughput: one item per cycle while in_ready is high; the frame state advances once per accepted item
// in_ready drops only while a result waits in the output register and out_ready is low
// reset (synchronous, rst_n low): line low, frame idle, auto-off cleared,
// output register empty, timing registers back to their defaults
module flash_led_one_wire_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_opcode,
  input  logic [15:0]                     in_request_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_line_level,
  output logic                            out_busy_res,
  output logic                            out_rejected,
  output logic                            out_timer_armed,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [flolc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [flolc_pkg::CfgDataW-1:0]  cfg_data
);
  import flolc_pkg::*;

  cfg_t cfg_r;
  res_t res, res_r;
  logic out_valid_r;
  logic accept;
  logic busy_now;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_time    <= RST_SHORT;
      cfg_r.long_time     <= RST_LONG;
      cfg_r.start_time    <= RST_START;
      cfg_r.end_low_time  <= RST_END_LOW;
      cfg_r.end_high_time <= RST_END_HIGH;
      cfg_r.auto_off_time <= RST_AUTO_OFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SHORT:    cfg_r.short_time    <= cfg_data[7:0];
        CFG_LONG:     cfg_r.long_time     <= cfg_data[7:0];
        CFG_START:    cfg_r.start_time    <= cfg_data[7:0];
        CFG_END_LOW:  cfg_r.end_low_time  <= cfg_data[7:0];
        CFG_END_HIGH: cfg_r.end_high_time <= cfg_data[11:0];
        CFG_AUTO_OFF: cfg_r.auto_off_time <= cfg_data;
        default:      ;
      endcase
    end
  end

  flolc_frame u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (accept),
    .opcode        (in_opcode),
    .request_value (in_request_value),
    .cfg           (cfg_r),
    .res           (res),
    .busy_now      (busy_now)
  );

  // output register: holds a result until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_line_level  = res_r.line_level;
  assign out_busy_res    = res_r.busy_res;
  assign out_rejected    = res_r.rejected;
  assign out_timer_armed = res_r.timer_armed;

  a_accept_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  a_tick_never_rejected : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == OP_TICK) |=> !out_rejected)
    else $error("tick item flagged as rejected");

  a_busy_request_rejected : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode != OP_TICK && busy_now) |=> out_rejected)
    else $error("request while busy was not rejected");

  a_busy_holds_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (!accept && busy_now) |=> busy_now)
    else $error("frame state moved without an accepted item");

endmodule

// File: rtl/core/flolc_decode.sv
`timescale 1ns / 1ps

module flolc_decode (
  input  logic [1:0]      opcode,
  input  logic [15:0]     request_value,
  output flolc_pkg::dec_t dec
);
  import flolc_pkg::*;

  logic [7:0] flash_step;

  assign flash_step = 8'(request_value[7:0] - BRIGHT_FLASH_LO[7:0]) + CMD_FLASH_BASE;

  always_comb begin
    dec = '0;
    if (request_value == 16'd0) begin
      dec.ok    = (opcode != OP_TICK);
      dec.first = CMD_OFF;
    end else begin
      unique case (opcode)
        OP_BRIGHT: begin
          if (request_value >= BRIGHT_TORCH_LO && request_value <= BRIGHT_TORCH_HI) begin
            dec.ok     = 1'b1;
            dec.first  = torch_code(2'(request_value[1:0] - 2'd1));
            dec.second = CMD_TORCH_TAIL;
            dec.two    = 1'b1;
          end else if ((request_value >= BRIGHT_FLASH_LO && request_value <= BRIGHT_FLASH_HI)
                       || request_value == BRIGHT_FULL) begin
            dec.ok     = 1'b1;
            dec.first  = (request_value < BRIGHT_FLASH_HI) ? flash_step : CMD_FLASH_MAX;
            dec.second = CMD_FLASH_TAIL;
            dec.two    = 1'b1;
            dec.flash  = 1'b1;
          end
        end
        OP_FLASH: begin
          if (request_value <= FLASH_MA_MAX) begin
            dec.ok     = 1'b1;
            dec.first  = CMD_FLASH_MAX;
            dec.second = CMD_FLASH_TAIL;
            dec.two    = 1'b1;
            dec.flash  = 1'b1;
          end
        end
        OP_TORCH: begin
          if (request_value <= TORCH_MA_MAX) begin
            dec.ok     = 1'b1;
            dec.first  = CMD_TORCH_DEF;
            dec.second = CMD_TORCH_TAIL;
            dec.two    = 1'b1;
          end
        end
        default: dec.ok = 1'b0;
      endcase
    end
  end

endmodule

// File: rtl/core/flolc_frame.sv
`timescale 1ns / 1ps

module flolc_frame (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [1:0]       opcode,
  input  logic [15:0]      request_value,
  input  flolc_pkg::cfg_t  cfg,
  output flolc_pkg::res_t  res,
  output logic             busy_now
);
  import flolc_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_START, PH_BLOW, PH_BHIGH, PH_ENDLOW, PH_ENDHIGH
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        line_r, line_nxt;
  logic [2:0]  bitpos_r, bitpos_nxt;
  logic [11:0] pcnt_r, pcnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  qbyte_r, qbyte_nxt;
  logic        qvalid_r, qvalid_nxt;
  logic [19:0] offcnt_r, offcnt_nxt;
  logic        offarmed_r, offarmed_nxt;
  logic        offwait_r, offwait_nxt;

  dec_t        dec;
  logic        req, start, done, rej;
  logic        cur_bit, next_bit;
  logic [19:0] cnt_dec;

  flolc_decode u_decode (
    .opcode        (opcode),
    .request_value (request_value),
    .dec           (dec)
  );

  assign busy_now = (phase_r != PH_IDLE) || qvalid_r;
  assign req      = (opcode != OP_TICK);
  assign start    = req && !busy_now && dec.ok;
  assign cur_bit  = shift_r[bitpos_r];
  assign next_bit = shift_r[3'(bitpos_r - 3'd1)];
  assign cnt_dec  = (offcnt_r != 20'd0) ? 20'(offcnt_r - 20'd1) : 20'd0;

  always_comb begin
    phase_nxt    = phase_r;
    line_nxt     = line_r;
    bitpos_nxt   = bitpos_r;
    pcnt_nxt     = pcnt_r;
    shift_nxt    = shift_r;
    qbyte_nxt    = qbyte_r;
    qvalid_nxt   = qvalid_r;
    offcnt_nxt   = offcnt_r;
    offarmed_nxt = offarmed_r;
    offwait_nxt  = offwait_r;
    done         = 1'b0;
    rej          = req && !start;

    if (start) begin
      shift_nxt  = dec.first;
      bitpos_nxt = 3'd7;
      phase_nxt  = PH_START;
      line_nxt   = 1'b1;
      pcnt_nxt   = at_least_one({4'd0, cfg.start_time});
      if (dec.two) begin
        qbyte_nxt  = dec.second;
        qvalid_nxt = 1'b1;
      end
      if (dec.flash) begin
        offwait_nxt = 1'b1;
      end
    end else if (phase_r != PH_IDLE) begin
      if (pcnt_r > 12'd1) begin
        pcnt_nxt = 12'(pcnt_r - 12'd1);
      end else begin
        unique case (phase_r)
          PH_START: begin
            phase_nxt = PH_BLOW;
            line_nxt  = 1'b0;
            pcnt_nxt  = at_least_one({4'd0, cur_bit ? cfg.short_time : cfg.long_time});
          end
          PH_BLOW: begin
            phase_nxt = PH_BHIGH;
            line_nxt  = 1'b1;
            pcnt_nxt  = at_least_one({4'd0, cur_bit ? cfg.long_time : cfg.short_time});
          end
          PH_BHIGH: begin
            line_nxt = 1'b0;
            if (bitpos_r == 3'd0) begin
              phase_nxt = PH_ENDLOW;
              pcnt_nxt  = at_least_one({4'd0, cfg.end_low_time});
            end else begin
              bitpos_nxt = 3'(bitpos_r - 3'd1);
              phase_nxt  = PH_BLOW;
              pcnt_nxt   = at_least_one({4'd0, next_bit ? cfg.short_time : cfg.long_time});
            end
          end
          PH_ENDLOW: begin
            phase_nxt = PH_ENDHIGH;
            line_nxt  = 1'b1;
            pcnt_nxt  = at_least_one(cfg.end_high_time);
          end
          PH_ENDHIGH: begin
            if (qvalid_r) begin
              qvalid_nxt = 1'b0;
              shift_nxt  = qbyte_r;
              bitpos_nxt = 3'd7;
              phase_nxt  = PH_START;
              line_nxt   = 1'b1;
              pcnt_nxt   = at_least_one({4'd0, cfg.start_time});
            end else begin
              phase_nxt = PH_IDLE;
              pcnt_nxt  = 12'd0;
              done      = 1'b1;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end

    // auto-off arms once the flash command sequence has gone out
    if (done && offwait_r) begin
      offwait_nxt = 1'b0;
      if (!offarmed_r) begin
        offarmed_nxt = 1'b1;
        offcnt_nxt   = cfg.auto_off_time;
      end
    end

    if (offarmed_r) begin
      offcnt_nxt = cnt_dec;
      if (cnt_dec == 20'd0 && phase_nxt == PH_IDLE && !qvalid_nxt) begin
        offarmed_nxt = 1'b0;
        shift_nxt    = CMD_OFF;
        bitpos_nxt   = 3'd7;
        phase_nxt    = PH_START;
        line_nxt     = 1'b1;
        pcnt_nxt     = at_least_one({4'd0, cfg.start_time});
      end
    end

    res.line_level  = line_nxt;
    res.busy_res    = (phase_nxt != PH_IDLE) || qvalid_nxt;
    res.rejected    = rej;
    res.timer_armed = offarmed_nxt || offwait_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      line_r     <= 1'b0;
      bitpos_r   <= 3'd0;
      pcnt_r     <= 12'd0;
      shift_r    <= 8'd0;
      qbyte_r    <= 8'd0;
      qvalid_r   <= 1'b0;
      offcnt_r   <= 20'd0;
      offarmed_r <= 1'b0;
      offwait_r  <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      line_r     <= line_nxt;
      bitpos_r   <= bitpos_nxt;
      pcnt_r     <= pcnt_nxt;
      shift_r    <= shift_nxt;
      qbyte_r    <= qbyte_nxt;
      qvalid_r   <= qvalid_nxt;
      offcnt_r   <= offcnt_nxt;
      offarmed_r <= offarmed_nxt;
      offwait_r  <= offwait_nxt;
    end
  end

endmodule

// File: test/flash_led_one_wire_controller_test.sv
`timescale 1ns / 1ps

module flash_led_one_wire_controller_test;
  import flolc_pkg::*;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_START,
    LN_BIT_LOW,
    LN_BIT_HIGH,
    LN_END_LOW,
    LN_END_HIGH
  } line_phase_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_opcode = OP_TICK;
  logic [15:0]         in_request_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_line_level;
  logic                out_busy_res;
  logic                out_rejected;
  logic                out_timer_armed;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // line predictor state
  cfg_t        tcfg;
  line_phase_t ln_phase;
  logic        line_q;
  logic [2:0]  bit_idx;
  logic [11:0] phase_left;
  logic [7:0]  tx_byte;
  logic [7:0]  next_byte;
  logic        next_valid;
  logic [19:0] off_left;
  logic        off_run;
  logic        off_hold;

  res_t predicted_line_q[$];
  res_t want;
  res_t seen;
  int   mismatch_count = 0;
  bit   no_idle = 1'b0;
  int   stall_left = 0;

  flash_led_one_wire_controller dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_request_value (in_request_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_line_level   (out_line_level),
    .out_busy_res     (out_busy_res),
    .out_rejected     (out_rejected),
    .out_timer_armed  (out_timer_armed),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void load_phase(line_phase_t ph, logic lvl, logic [11:0] ticks);
    ln_phase = ph;
    line_q = lvl;
    // a zero duration still takes one tick
    phase_left = (ticks == 12'd0) ? 12'd1 : ticks;
  endfunction

  function automatic void load_bit();
    load_phase(LN_BIT_LOW, 1'b0,
               {4'd0, tx_byte[bit_idx] ? tcfg.short_time : tcfg.long_time});
  endfunction

  function automatic void load_byte(logic [7:0] b);
    tx_byte = b;
    bit_idx = 3'd7;
    load_phase(LN_START, 1'b1, {4'd0, tcfg.start_time});
  endfunction

  function automatic logic line_busy();
    return (ln_phase != LN_IDLE) || next_valid;
  endfunction

  // one tick of a running frame, 1 when the last queued frame has closed
  function automatic logic phase_tick();
    if (ln_phase == LN_IDLE) return 1'b0;
    if (phase_left > 12'd1) begin
      phase_left = phase_left - 12'd1;
      return 1'b0;
    end
    case (ln_phase)
      LN_START: load_bit();
      LN_BIT_LOW: begin
        load_phase(LN_BIT_HIGH, 1'b1,
                   {4'd0, tx_byte[bit_idx] ? tcfg.long_time : tcfg.short_time});
      end
      LN_BIT_HIGH: begin
        if (bit_idx == 3'd0) begin
          load_phase(LN_END_LOW, 1'b0, {4'd0, tcfg.end_low_time});
        end else begin
          bit_idx = bit_idx - 3'd1;
          load_bit();
        end
      end
      LN_END_LOW: load_phase(LN_END_HIGH, 1'b1, tcfg.end_high_time);
      default: begin
        if (next_valid) begin
          next_valid = 1'b0;
          load_byte(next_byte);
        end else begin
          ln_phase = LN_IDLE;
          phase_left = '0;
          return 1'b1;
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic dec_t cmd_decode(logic [1:0] op, logic [15:0] v);
    dec_t d;
    logic [15:0] rel;
    d = '0;
    if (v == 16'd0) begin
      d.ok = 1'b1;
      d.first = CMD_OFF;
    end else if (op == OP_BRIGHT) begin
      if (v >= BRIGHT_TORCH_LO && v <= BRIGHT_TORCH_HI) begin
        rel = v - BRIGHT_TORCH_LO;
        d.ok = 1'b1;
        case (rel[1:0])
          2'd0:    d.first = 8'h61;
          2'd1:    d.first = 8'h63;
          2'd2:    d.first = 8'h65;
          default: d.first = 8'h64;
        endcase
        d.second = CMD_TORCH_TAIL;
        d.two = 1'b1;
      end else if ((v >= BRIGHT_FLASH_LO && v <= BRIGHT_FLASH_HI) || v == BRIGHT_FULL) begin
        rel = v - BRIGHT_FLASH_LO;
        d.ok = 1'b1;
        d.first = (v < BRIGHT_FLASH_HI) ? CMD_FLASH_BASE + rel[7:0] : CMD_FLASH_MAX;
        d.second = CMD_FLASH_TAIL;
        d.two = 1'b1;
        d.flash = 1'b1;
      end
    end else if (op == OP_FLASH) begin
      if (v <= FLASH_MA_MAX) begin
        d.ok = 1'b1;
        d.first = CMD_FLASH_MAX;
        d.second = CMD_FLASH_TAIL;
        d.two = 1'b1;
        d.flash = 1'b1;
      end
    end else if (v <= TORCH_MA_MAX) begin
      d.ok = 1'b1;
      d.first = CMD_TORCH_DEF;
      d.second = CMD_TORCH_TAIL;
      d.two = 1'b1;
    end
    return d;
  endfunction

  // predicts the line after one accepted item
  function automatic res_t line_step(logic [1:0] op, logic [15:0] v);
    dec_t d;
    logic started;
    logic armed_now;
    res_t r;
    started = 1'b0;
    armed_now = 1'b0;
    r = '0;
    if (op != OP_TICK) begin
      d = cmd_decode(op, v);
      if (line_busy() || !d.ok) begin
        r.rejected = 1'b1;
      end else begin
        load_byte(d.first);
        if (d.two) begin
          next_byte = d.second;
          next_valid = 1'b1;
        end
        if (d.flash) off_hold = 1'b1;
        started = 1'b1;
      end
    end
    if (!started) begin
      if (phase_tick() && off_hold) begin
        off_hold = 1'b0;
        // a countdown already running is left alone
        if (!off_run) begin
          off_run = 1'b1;
          off_left = tcfg.auto_off_time;
          armed_now = 1'b1;
        end
      end
    end
    if (off_run && !armed_now) begin
      if (off_left != 20'd0) off_left = off_left - 20'd1;
      if (off_left == 20'd0 && !line_busy()) begin
        off_run = 1'b0;
        load_byte(CMD_OFF);
      end
    end
    r.line_level = line_q;
    r.busy_res = line_busy();
    r.timer_armed = off_run | off_hold;
    return r;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [15:0] val);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predicted_line_q.push_back(line_step(op, val));
    in_opcode <= op;
    in_request_value <= val;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_until_free();
    while (line_busy()) send_item(OP_TICK, 16'($urandom_range(0, 65535)));
  endtask

  // stop sending and let every result come back
  task automatic wait_results();
    release_input();
    while (predicted_line_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // tick until line and timer are quiet, then let every result come back
  task automatic drain();
    while (line_busy() || off_run || off_hold) begin
      send_item(OP_TICK, 16'($urandom_range(0, 65535)));
    end
    wait_results();
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SHORT:    tcfg.short_time = val[7:0];
      CFG_LONG:     tcfg.long_time = val[7:0];
      CFG_START:    tcfg.start_time = val[7:0];
      CFG_END_LOW:  tcfg.end_low_time = val[7:0];
      CFG_END_HIGH: tcfg.end_high_time = val[11:0];
      CFG_AUTO_OFF: tcfg.auto_off_time = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_timing(input logic [7:0] s, input logic [7:0] l, input logic [7:0] st,
                            input logic [7:0] el, input logic [11:0] eh,
                            input logic [19:0] ao);
    write_reg(CFG_SHORT, {12'd0, s});
    write_reg(CFG_LONG, {12'd0, l});
    write_reg(CFG_START, {12'd0, st});
    write_reg(CFG_END_LOW, {12'd0, el});
    write_reg(CFG_END_HIGH, {8'd0, eh});
    write_reg(CFG_AUTO_OFF, ao);
  endtask

  task automatic try_request(input logic [1:0] op, input logic [15:0] val);
    send_item(op, val);
    drain();
  endtask

  function automatic logic [7:0] rand_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 8'($urandom_range(0, 4));
    if (r < 95) return 8'($urandom_range(5, 16));
    return 8'($urandom_range(17, 60));
  endfunction

  task automatic test_reset_defaults();
    // line sits low until the first frame
    repeat (3) send_item(OP_TICK, 16'($urandom_range(0, 65535)));
    send_item(OP_BRIGHT, 16'd0);
    send_item(OP_TORCH, 16'd1);
    // into the first bit; the rest of the frame runs under the next timing
    repeat (40) send_item(OP_TICK, 16'($urandom_range(0, 65535)));
    wait_results();
  endtask

  task automatic test_timing_extremes();
    // zero durations, and an auto-off that comes due while the next frame runs
    set_timing(8'd0, 8'd0, 8'd0, 8'd0, 12'd0, 20'd0);
    run_until_free();
    send_item(OP_FLASH, 16'd1);
    run_until_free();
    send_item(OP_BRIGHT, 16'd127);
    drain();
    no_idle = 1'b1;
    set_timing(8'hFF, 8'hFF, 8'hFF, 8'hFF, 12'hFFF, 20'hFFFFF);
    send_item(OP_TORCH, 16'd0);
    repeat (20) send_item(OP_TICK, 16'($urandom_range(0, 65535)));
    wait_results();
    no_idle = 1'b0;
  endtask

  task automatic test_request_map();
    set_timing(8'd1, 8'd2, 8'd1, 8'd1, 12'd2, 20'd3);
    run_until_free();
    send_item(OP_TICK, 16'hFFFF);
    try_request(OP_BRIGHT, 16'd0);
    try_request(OP_BRIGHT, 16'd124);
    try_request(OP_BRIGHT, 16'd125);
    try_request(OP_BRIGHT, 16'd126);
    try_request(OP_BRIGHT, 16'd127);
    try_request(OP_BRIGHT, 16'd128);
    try_request(OP_BRIGHT, 16'd129);
    try_request(OP_BRIGHT, 16'd141);
    try_request(OP_BRIGHT, 16'd142);
    try_request(OP_BRIGHT, 16'd143);
    try_request(OP_BRIGHT, 16'd255);
    try_request(OP_BRIGHT, 16'hFFFF);
    try_request(OP_FLASH, 16'd0);
    try_request(OP_FLASH, 16'd1000);
    try_request(OP_FLASH, 16'd1001);
    try_request(OP_TORCH, 16'd224);
    try_request(OP_TORCH, 16'd225);
  endtask

  task automatic test_auto_off();
    // two-byte frames take 56 ticks here, the countdown 150
    set_timing(8'd1, 8'd2, 8'd1, 8'd1, 12'd2, 20'd150);
    send_item(OP_FLASH, 16'd500);
    send_item(OP_TORCH, 16'd1);
    run_until_free();
    // countdown already running, not restarted
    send_item(OP_FLASH, 16'd2);
    run_until_free();
    send_item(OP_BRIGHT, 16'd0);
    run_until_free();
    send_item(OP_TORCH, 16'd1);
    run_until_free();
    // expiry falls inside this frame and is held back
    send_item(OP_TORCH, 16'd224);
    drain();
  endtask

  task automatic test_random_traffic();
    logic [1:0]  op;
    logic [15:0] val;
    int          pick;
    for (int ph = 0; ph < 3; ph++) begin
      no_idle = (ph == 2);
      set_timing(rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks(), {4'd0, rand_ticks()},
                 20'($urandom_range(0, 300)));
      repeat (80) begin
        // requests mostly when the line is free, so they get past the busy check
        if ($urandom_range(0, 99) < (line_busy() ? 4 : 45)) begin
          op = 2'($urandom_range(1, 3));
          pick = $urandom_range(0, 9);
          if (pick == 0) begin
            val = 16'd0;
          end else if (pick < 7) begin
            case (op)
              OP_BRIGHT: begin
                val = 16'($urandom_range(125, 143));
                if (val == 16'd143) val = BRIGHT_FULL;
              end
              OP_FLASH: val = 16'($urandom_range(1, 1000));
              default:  val = 16'($urandom_range(1, 224));
            endcase
          end else begin
            val = 16'($urandom_range(0, 65535));
          end
          send_item(op, val);
        end else begin
          send_item(OP_TICK, 16'($urandom_range(0, 65535)));
        end
      end
      drain();
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left = idle_len();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (predicted_line_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: result transfer with none expected", $time);
      end else begin
        want = predicted_line_q.pop_front();
        seen = {out_line_level, out_busy_res, out_rejected, out_timer_armed};
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: line/busy/rej/armed expected %b%b%b%b, got %b%b%b%b",
                     $time, want.line_level, want.busy_res, want.rejected, want.timer_armed,
                     seen.line_level, seen.busy_res, seen.rejected, seen.timer_armed);
          end
        end
      end
    end
  end

  initial begin
    tcfg.short_time = RST_SHORT;
    tcfg.long_time = RST_LONG;
    tcfg.start_time = RST_START;
    tcfg.end_low_time = RST_END_LOW;
    tcfg.end_high_time = RST_END_HIGH;
    tcfg.auto_off_time = RST_AUTO_OFF;
    ln_phase = LN_IDLE;
    line_q = 1'b0;
    bit_idx = '0;
    phase_left = '0;
    tx_byte = '0;
    next_byte = '0;
    next_valid = 1'b0;
    off_left = '0;
    off_run = 1'b0;
    off_hold = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_timing_extremes();
    test_request_map();
    test_auto_off();
    test_random_traffic();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
